// File: design/utf8u2_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package utf8u2_pkg;

    localparam int BYTE_W  = 8;
    localparam int UNIT_W  = 16;
    localparam int COUNT_W = 16;
    localparam int PEND_W  = 3;
    localparam int SHIFT_W = 6;

    // Capacity after reset: the whole 16-bit range
    localparam logic [COUNT_W-1:0] CAP_RESET = '1;

    // Continuation bytes expected after each lead form
    localparam logic [PEND_W-1:0] PEND_LEAD2 = 3'd1;
    localparam logic [PEND_W-1:0] PEND_LEAD3 = 3'd2;
    localparam logic [PEND_W-1:0] PEND_LEAD4 = 3'd3;
    localparam logic [PEND_W-1:0] PEND_LEAD5 = 3'd4;
    localparam logic [PEND_W-1:0] PEND_LEAD6 = 3'd5;

    // Pipeline control between the input stage and the result register
    typedef struct packed {
        logic advance;   // input stage hands its byte on this cycle
        logic produce;   // the byte yields a result item
        logic emit;      // the byte yields a new code unit
    } t_step_ctl;

endpackage

`default_nettype wire

// File: design/utf8_to_ucs2_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// UTF-8 to 16-bit code unit decoder.
// Slave stream: one UTF-8 byte per transaction in s_axis_tdata, with tlast on the
// final byte of a string. Master stream: one result per byte that emits a code unit
// or ends a string; tdata holds code_unit and the running unit_count, tuser
// flags a newly emitted unit, tlast marks the result of the final byte. Bytes that
// only open or extend a sequence, stray continuations and bytes past capacity
// produce no result unless they end a string.
// Configuration: a write on the cfg channel sets the per-string capacity; write it
// only while no byte or result is in flight. A write between two bytes of a string
// applies to the bytes that follow. A capacity of zero emits nothing.
// Each result passes the input register, then the result register. Throughput: one
// byte per cycle while the receiver does not stall, set by the single decode step
// between the registers; while a result waits, only a byte yielding no result moves on.
// Reset (synchronous, active low) empties both registers, clears the string state
// and sets capacity to 65535.
// Receiver stall: the result register holds; a byte that yields no result still
// drains, and once the input register backs up s_axis_tready drops.
module utf8_to_ucs2_decoder_unit
    import utf8u2_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // byte_in [7:0]
    input  wire logic [BYTE_W-1:0]    i_s_axis_tdata,
    input  wire logic                 i_s_axis_tlast,
    input  wire logic                 i_s_axis_tvalid,
    output      logic                 o_s_axis_tready,
    // code_unit [15:0], unit_count [31:16]
    output      logic [UNIT_W+COUNT_W-1:0] o_m_axis_tdata,
    // unit_valid [0]
    output      logic                 o_m_axis_tuser,
    output      logic                 o_m_axis_tlast,
    output      logic                 o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    input  wire logic [COUNT_W-1:0]   i_cfg_data,
    input  wire logic                 i_cfg_valid,
    output      logic                 o_cfg_ready
);

    logic [COUNT_W-1:0] r_capacity;

    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_byte;
    logic               r_last;

    logic [UNIT_W-1:0]  r_partial;
    logic [PEND_W-1:0]  r_pending;
    logic [COUNT_W-1:0] r_units;
    logic               r_full;

    logic               r_out_valid;
    logic [UNIT_W-1:0]  r_out_unit;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_flag;
    logic               r_out_last;

    logic [UNIT_W-1:0]  n_partial;
    logic [PEND_W-1:0]  n_pending;
    logic [COUNT_W-1:0] n_units;
    logic               n_full;
    logic [UNIT_W-1:0]  n_unit;

    logic               full_now;
    logic               out_free;
    t_step_ctl          ctl;

    // Configuration register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    // Decode one byte against the string state
    always_comb begin
        n_partial = r_partial;
        n_pending = r_pending;
        n_units   = r_units;
        n_unit    = '0;
        ctl.emit  = 1'b0;
        full_now  = r_full || (r_units >= r_capacity);

        if (!full_now) begin
            unique case (r_byte) inside
                8'b10??????: begin
                    n_partial = {r_partial[UNIT_W-SHIFT_W-1:0], r_byte[SHIFT_W-1:0]};
                    if (r_pending != '0) begin
                        n_pending = r_pending - 1'b1;
                        if (r_pending == PEND_LEAD2) begin
                            ctl.emit = 1'b1;
                            n_unit   = n_partial;
                        end
                    end
                end
                8'b0???????: begin
                    ctl.emit = 1'b1;
                    n_unit   = {{(UNIT_W-BYTE_W){1'b0}}, r_byte};
                end
                8'b110?????: begin
                    n_partial = {{(UNIT_W-5){1'b0}}, r_byte[4:0]};
                    n_pending = PEND_LEAD2;
                end
                8'b1110????: begin
                    n_partial = {{(UNIT_W-4){1'b0}}, r_byte[3:0]};
                    n_pending = PEND_LEAD3;
                end
                8'b11110???: begin
                    n_partial = {{(UNIT_W-3){1'b0}}, r_byte[2:0]};
                    n_pending = PEND_LEAD4;
                end
                8'b111110??: begin
                    n_partial = {{(UNIT_W-2){1'b0}}, r_byte[1:0]};
                    n_pending = PEND_LEAD5;
                end
                default: begin
                    n_partial = {{(UNIT_W-1){1'b0}}, r_byte[0]};
                    n_pending = PEND_LEAD6;
                end
            endcase
        end

        if (ctl.emit) begin
            n_units = r_units + 1'b1;
        end
        n_full = full_now || (ctl.emit && (n_units >= r_capacity));

        ctl.produce = ctl.emit || r_last;
        out_free    = !r_out_valid || i_m_axis_tready;
        ctl.advance = r_in_valid && (!ctl.produce || out_free);
    end

    assign o_s_axis_tready = !r_in_valid || ctl.advance;

    // Input register: load on every accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_byte <= i_s_axis_tdata;
            r_last <= i_s_axis_tlast;
        end
    end

    // String state: advance with each byte, clear after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_pending <= '0;
            r_units   <= '0;
            r_full    <= 1'b0;
        end else if (ctl.advance) begin
            if (r_last) begin
                r_partial <= '0;
                r_pending <= '0;
                r_units   <= '0;
                r_full    <= 1'b0;
            end else begin
                r_partial <= n_partial;
                r_pending <= n_pending;
                r_units   <= n_units;
                r_full    <= n_full;
            end
        end
    end

    // Result register: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= ctl.advance && ctl.produce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && ctl.advance && ctl.produce) begin
            r_out_unit  <= n_unit;
            r_out_count <= n_units;
            r_out_flag  <= ctl.emit;
            r_out_last  <= r_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_count, r_out_unit};
    assign o_m_axis_tuser  = r_out_flag;
    assign o_m_axis_tlast  = r_out_last;

    // Every result carries a unit, a string end, or both
    a_result_has_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser || o_m_axis_tlast))
        else $error("result with neither unit nor string end");

    // An emitted unit is always counted
    a_unit_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata[UNIT_W +: COUNT_W] != '0))
        else $error("emitted unit with zero count");

    // Without a unit the code unit field reads zero
    a_unit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata[UNIT_W-1:0] == '0))
        else $error("nonzero code unit without emission");

    // A sequence never expects more than five continuation bytes
    a_pending_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= PEND_LEAD6)
        else $error("pending count out of range");

    // The last byte of a string leaves a clean state behind
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.advance && r_last) |=> (r_units == '0 && r_pending == '0 && !r_full))
        else $error("string state not cleared after last byte");

endmodule

`default_nettype wire
